FILE: design/sdls_pkg.sv
// ----------------------------------------------------------------------------
// sdls_pkg
// widths, types and cofactor index tables for the small dense linear solver
// ----------------------------------------------------------------------------
package sdls_pkg;

  localparam int W  = 32;
  localparam int FB = 16;
  localparam int NA = 9;
  localparam int NB = 3;
  localparam int NP = 12;
  localparam int PW = 2 * W;
  localparam int CW = PW + 1;
  localparam int SW = CW + W + 2;
  localparam int QB = W;
  localparam int RW = SW + QB;

  typedef logic signed [W-1:0]  val_t;
  typedef logic signed [CW-1:0] cof_t;
  typedef logic signed [SW-1:0] sum_t;
  typedef logic signed [PW:0]   part_t;
  typedef logic [1:0]           dim_t;
  typedef logic [3:0]           idx_t;

  typedef logic [NA-1:0][W-1:0]  mat_t;
  typedef logic [NB-1:0][W-1:0]  vec_t;
  typedef logic [NA-1:0][CW-1:0] adj_t;

  typedef struct packed {
    logic valid;
    logic dim2;
  } ctl_t;

  localparam dim_t DIM_2D    = 2'd2;
  localparam dim_t DIM_RESET = 2'd3;

  // adjugate entry k = a[CF_A]*a[CF_B] - a[CF_C]*a[CF_D], row-major
  localparam idx_t CF_A [NA] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam idx_t CF_B [NA] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam idx_t CF_C [NA] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam idx_t CF_D [NA] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

endpackage

FILE: design/sdls_cof.sv
// ----------------------------------------------------------------------------
// sdls_cof
// input register, cofactor products and adjugate with 2x2 selection
// ----------------------------------------------------------------------------
module sdls_cof import sdls_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  ctl_t in_ctl,
  input  mat_t in_a,
  input  vec_t in_b,
  output ctl_t out_ctl,
  output adj_t out_inv,
  output vec_t out_a0,
  output vec_t out_b,
  output cof_t out_det2
);

  ctl_t c1_r, c2_r, c3_r;
  mat_t a1_r, a2_r;
  vec_t b1_r, b2_r, b3_r, a0_r;
  logic [NA-1:0][PW-1:0] p_r, q_r, p_nxt, q_nxt;
  adj_t inv_r, inv_nxt;
  cof_t det2_r, det2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
    end else if (en) begin
      c1_r <= in_ctl;
      c2_r <= c1_r;
      c3_r <= c2_r;
    end
  end

  always_comb begin
    logic signed [PW-1:0] xa, xb, xc, xd;
    for (int k = 0; k < NA; k++) begin
      xa = PW'(val_t'(a1_r[CF_A[k]]));
      xb = PW'(val_t'(a1_r[CF_B[k]]));
      xc = PW'(val_t'(a1_r[CF_C[k]]));
      xd = PW'(val_t'(a1_r[CF_D[k]]));
      p_nxt[k] = xa * xb;
      q_nxt[k] = xc * xd;
    end
  end

  always_comb begin
    cof_t c [NA];
    for (int k = 0; k < NA; k++) begin
      c[k] = CW'($signed(p_r[k])) - CW'($signed(q_r[k]));
      inv_nxt[k] = c2_r.dim2 ? '0 : c[k];
    end
    if (c2_r.dim2) begin
      inv_nxt[0] = CW'(val_t'(a2_r[4]));
      inv_nxt[1] = -CW'(val_t'(a2_r[1]));
      inv_nxt[3] = -CW'(val_t'(a2_r[3]));
      inv_nxt[4] = CW'(val_t'(a2_r[0]));
    end
    det2_nxt = c[8];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= in_a;
      b1_r   <= in_b;
      p_r    <= p_nxt;
      q_r    <= q_nxt;
      a2_r   <= a1_r;
      b2_r   <= b1_r;
      inv_r  <= inv_nxt;
      det2_r <= det2_nxt;
      b3_r   <= b2_r;
      a0_r   <= a2_r[2:0];
    end
  end

  assign out_ctl  = c3_r;
  assign out_inv  = inv_r;
  assign out_a0   = a0_r;
  assign out_b    = b3_r;
  assign out_det2 = det2_r;

endmodule

FILE: design/sdls_mac.sv
// ----------------------------------------------------------------------------
// sdls_mac
// split wide products and sums for determinant and numerators
// ----------------------------------------------------------------------------
module sdls_mac import sdls_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  ctl_t in_ctl,
  input  adj_t in_inv,
  input  vec_t in_a0,
  input  vec_t in_b,
  input  cof_t in_det2,
  output logic out_valid,
  output sum_t out_det,
  output logic [NB-1:0][SW-1:0] out_num
);

  ctl_t c1_r, c2_r, c3_r;
  logic [NP-1:0][PW:0] lo_r, hi_r, lo_nxt, hi_nxt;
  logic [NP-1:0][SW-1:0] pr_r, pr_nxt;
  cof_t d1_r, d2_r;
  sum_t det_r, det_nxt;
  logic [NB-1:0][SW-1:0] num_r, num_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
    end else if (en) begin
      c1_r <= in_ctl;
      c2_r <= c1_r;
      c3_r <= c2_r;
    end
  end

  // products 0..2 feed the determinant, 3+3i+j feed numerator i
  always_comb begin
    val_t  x;
    cof_t  y;
    part_t xe, ylo, yhi;
    for (int m = 0; m < NP; m++) begin
      if (m < NB) begin
        x = val_t'(in_a0[m]);
        y = cof_t'(in_inv[m * NB]);
      end else begin
        x = val_t'(in_b[(m - NB) % NB]);
        y = cof_t'(in_inv[m - NB]);
      end
      xe  = (PW + 1)'(x);
      ylo = (PW + 1)'(y[W-1:0]);
      yhi = (PW + 1)'($signed(y[CW-1:W]));
      lo_nxt[m] = xe * ylo;
      hi_nxt[m] = xe * yhi;
    end
  end

  always_comb begin
    for (int m = 0; m < NP; m++) begin
      pr_nxt[m] = (SW'($signed(hi_r[m])) <<< W) + SW'($signed(lo_r[m]));
    end
  end

  always_comb begin
    det_nxt = c2_r.dim2 ? SW'(d2_r)
                        : $signed(pr_r[0]) + $signed(pr_r[1]) + $signed(pr_r[2]);
    for (int i = 0; i < NB; i++) begin
      num_nxt[i] = $signed(pr_r[NB + NB * i]) + $signed(pr_r[NB + NB * i + 1])
                 + $signed(pr_r[NB + NB * i + 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      d1_r  <= in_det2;
      pr_r  <= pr_nxt;
      d2_r  <= d1_r;
      det_r <= det_nxt;
      num_r <= num_nxt;
    end
  end

  assign out_valid = c3_r.valid;
  assign out_det   = det_r;
  assign out_num   = num_r;

endmodule

FILE: design/sdls_div.sv
// ----------------------------------------------------------------------------
// sdls_div
// pipelined restoring divider, one quotient bit per stage, with saturation
// ----------------------------------------------------------------------------
module sdls_div import sdls_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  sum_t in_num,
  input  sum_t in_det,
  output logic out_valid,
  output val_t out_x,
  output logic out_sat,
  output logic out_zero
);

  logic          v0_r, neg0_r, dz0_r;
  logic [SW-1:0] nm_r, dm_r;

  logic [RW-1:0] rem_r [QB+1];
  logic [SW-1:0] d_r   [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic          v_r   [QB+1];
  logic          neg_r [QB+1];
  logic          ovf_r [QB+1];
  logic          dz_r  [QB+1];

  logic vo_r, sat_r, sat_nxt, zero_r;
  val_t x_r, x_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v_r[0] <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v_r[0] <= v0_r;
      vo_r <= v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm_r     <= in_num[SW-1] ? SW'(-in_num) : SW'(in_num);
      dm_r     <= in_det[SW-1] ? SW'(-in_det) : SW'(in_det);
      neg0_r   <= in_num[SW-1] ^ in_det[SW-1];
      dz0_r    <= (in_det == '0);
      rem_r[0] <= RW'(nm_r) << FB;
      d_r[0]   <= dm_r;
      q_r[0]   <= '0;
      neg_r[0] <= neg0_r;
      dz_r[0]  <= dz0_r;
      ovf_r[0] <= (RW'(nm_r) << FB) >= (RW'(dm_r) << QB);
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int K = QB - 1 - s;
    logic [RW-1:0] t;
    logic          ge;
    assign t  = RW'(d_r[s]) << K;
    assign ge = rem_r[s] >= t;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= ge ? rem_r[s] - t : rem_r[s];
        q_r[s+1]   <= {q_r[s][QB-2:0], ge};
        d_r[s+1]   <= d_r[s];
        neg_r[s+1] <= neg_r[s];
        ovf_r[s+1] <= ovf_r[s];
        dz_r[s+1]  <= dz_r[s];
      end
    end
  end

  always_comb begin
    logic [QB-1:0] q;
    logic          neg;
    q   = q_r[QB];
    neg = neg_r[QB];
    sat_nxt = 1'b0;
    x_nxt   = '0;
    if (!dz_r[QB]) begin
      if (ovf_r[QB] || (q[QB-1] && (!neg || (q[QB-2:0] != '0)))) begin
        sat_nxt = 1'b1;
        x_nxt   = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        x_nxt = neg ? val_t'(-q) : val_t'(q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      sat_r  <= sat_nxt;
      zero_r <= dz_r[QB];
    end
  end

  assign out_valid = vo_r;
  assign out_x     = x_r;
  assign out_sat   = sat_r;
  assign out_zero  = zero_r;

endmodule

FILE: design/small_dense_linear_solve.sv
// throughput: one item per cycle; a stalled result holds the whole pipeline
// the 32 stage restoring divider sets the depth, one quotient bit per stage
// reset: synchronous active-low, clears valid bits, dimension returns to 3
// ----------------------------------------------------------------------------
// small_dense_linear_solve
// 3x3 or 2x2 linear solve by adjugate and determinant, signed q16.16
// ----------------------------------------------------------------------------
module small_dense_linear_solve import sdls_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_data,    // dimension
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [383:0]   in_tdata,    // a00 a01 a02 a10 a11 a12 a20 a21 a22 b0 b1 b2
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [95:0]    out_tdata,   // x0 x1 x2
  output logic [1:0]     out_tuser    // singular saturated
);

  dim_t dim_r;
  logic en;
  ctl_t in_ctl, cof_ctl;
  mat_t in_a;
  vec_t in_b, cof_a0, cof_b;
  adj_t cof_inv;
  cof_t cof_det2;
  logic mac_valid;
  sum_t mac_det;
  logic [NB-1:0][SW-1:0] mac_num;
  logic [NB-1:0] dv, ds, dz;
  val_t dx [NB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_RESET;
    end else if (cfg_valid) begin
      dim_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  assign in_ctl.valid = in_tvalid;
  assign in_ctl.dim2  = (dim_r == DIM_2D);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      in_a[i] = in_tdata[i*W +: W];
    end
    for (int j = 0; j < NB; j++) begin
      in_b[j] = in_tdata[(NA + j)*W +: W];
    end
  end

  sdls_cof u_cof (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_ctl   (in_ctl),
    .in_a     (in_a),
    .in_b     (in_b),
    .out_ctl  (cof_ctl),
    .out_inv  (cof_inv),
    .out_a0   (cof_a0),
    .out_b    (cof_b),
    .out_det2 (cof_det2)
  );

  sdls_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_ctl    (cof_ctl),
    .in_inv    (cof_inv),
    .in_a0     (cof_a0),
    .in_b      (cof_b),
    .in_det2   (cof_det2),
    .out_valid (mac_valid),
    .out_det   (mac_det),
    .out_num   (mac_num)
  );

  for (genvar i = 0; i < NB; i++) begin : g_div
    sdls_div u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (mac_valid),
      .in_num    (sum_t'(mac_num[i])),
      .in_det    (mac_det),
      .out_valid (dv[i]),
      .out_x     (dx[i]),
      .out_sat   (ds[i]),
      .out_zero  (dz[i])
    );
  end

  assign out_tvalid = dv[0];
  assign out_tdata  = {dx[2], dx[1], dx[0]};
  assign out_tuser  = {(|ds) && !dz[0], dz[0]};

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// streams 2x2 and 3x3 signed q16.16 systems through the solver and checks
// every solution against an adjugate and determinant predictor kept here
// ----------------------------------------------------------------------------
module tb_top;
  import sdls_pkg::*;

  localparam int LAT        = 41;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic signed [31:0] x0, x1, x2;
    logic               singular, saturated;
  } soln_t;

  logic           clk;
  logic           rst_n;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [1:0]     cfg_data;
  logic           in_tvalid;
  logic           in_tready;
  logic [383:0]   in_tdata;
  logic           out_tvalid;
  logic           out_tready;
  logic [95:0]    out_tdata;
  logic [1:0]     out_tuser;

  logic [1:0]     dim_model;
  soln_t          soln_q[$];
  int             err_cnt;
  int             idle_cnt;
  int             burst_left;
  int             stall_mode;

  small_dense_linear_solve u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // truncating divide with saturation, den nonzero
  function automatic logic signed [31:0] div_sat(input logic signed [255:0] num,
                                                 input logic signed [255:0] den,
                                                 inout logic sat);
    logic signed [255:0] q;
    q = (num <<< FB) / den;
    if (q > 256'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (q < -256'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  function automatic soln_t solve_system(input logic [383:0] d, input logic [1:0] dim);
    logic signed [255:0] a [9];
    logic signed [255:0] b [3];
    logic signed [255:0] adj [9];
    logic signed [255:0] det;
    logic signed [255:0] num [3];
    soln_t r;
    logic sat;
    for (int i = 0; i < 9; i++) a[i] = $signed(d[32*i +: 32]);
    for (int i = 0; i < 3; i++) b[i] = $signed(d[288 + 32*i +: 32]);
    r = '{0, 0, 0, 0, 0};
    sat = 1'b0;
    if (dim == DIM_2D) begin
      det = a[0]*a[4] - a[1]*a[3];
      num[0] = a[4]*b[0] - a[1]*b[1];
      num[1] = a[0]*b[1] - a[3]*b[0];
      num[2] = 0;
    end else begin
      adj[0] = a[4]*a[8] - a[5]*a[7];
      adj[1] = a[2]*a[7] - a[1]*a[8];
      adj[2] = a[1]*a[5] - a[2]*a[4];
      adj[3] = a[5]*a[6] - a[3]*a[8];
      adj[4] = a[0]*a[8] - a[2]*a[6];
      adj[5] = a[2]*a[3] - a[0]*a[5];
      adj[6] = a[3]*a[7] - a[4]*a[6];
      adj[7] = a[1]*a[6] - a[0]*a[7];
      adj[8] = a[0]*a[4] - a[1]*a[3];
      det = a[0]*adj[0] + a[1]*adj[3] + a[2]*adj[6];
      for (int i = 0; i < 3; i++)
        num[i] = adj[3*i]*b[0] + adj[3*i+1]*b[1] + adj[3*i+2]*b[2];
    end
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    r.x0 = div_sat(num[0], det, sat);
    r.x1 = div_sat(num[1], det, sat);
    if (dim != DIM_2D) r.x2 = div_sat(num[2], det, sat);
    r.saturated = sat;
    return r;
  endfunction

  // receiver stall pattern and result check
  always @(posedge clk) begin
    soln_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
      if (out_tvalid && out_tready) begin
        if (soln_q.size() == 0) begin
          $error("result with no expectation");
          err_cnt++;
        end else begin
          e = soln_q.pop_front();
          if ($signed(out_tdata[31:0]) != e.x0) begin
            $error("x0 exp %0d got %0d", e.x0, $signed(out_tdata[31:0])); err_cnt++;
          end
          if ($signed(out_tdata[63:32]) != e.x1) begin
            $error("x1 exp %0d got %0d", e.x1, $signed(out_tdata[63:32])); err_cnt++;
          end
          if ($signed(out_tdata[95:64]) != e.x2) begin
            $error("x2 exp %0d got %0d", e.x2, $signed(out_tdata[95:64])); err_cnt++;
          end
          if (out_tuser[0] != e.singular) begin
            $error("singular exp %0d got %0d", e.singular, out_tuser[0]); err_cnt++;
          end
          if (out_tuser[1] != e.saturated) begin
            $error("saturated exp %0d got %0d", e.saturated, out_tuser[1]); err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic send_item(input logic [383:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    soln_q.push_back(solve_system(d, dim_model));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (soln_q.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic write_dim(input logic [1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dim_model = v;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
      3: return $urandom_range(0, 8) - 4;
      4: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [383:0] rand_system();
    logic [383:0] d;
    for (int i = 0; i < 12; i++) d[32*i +: 32] = rand_val();
    // force some singular matrices: copy one row over another
    if ($urandom_range(0, 9) == 0) d[96 +: 96] = d[0 +: 96];
    return d;
  endfunction

  task automatic test_directed();
    logic [383:0] d;
    logic [31:0] one;
    one = 32'h00010000;
    d = '0;
    send_item(d);                                       // all zero, singular
    d = {one, one, one, one, 32'h0, 32'h0, 32'h0, one, 32'h0, 32'h0, 32'h0, one};
    send_item(d);                                       // identity
    d = {{3{32'h7fffffff}}, 32'h00000001, 32'h0, 32'h0, 32'h0, 32'h00000001, 32'h0,
         32'h0, 32'h0, 32'h00000001};
    send_item(d);                                       // tiny diagonal, saturate
    d = {{3{32'h80000000}}, 32'h00000001, 32'h0, 32'h0, 32'h0, 32'h00000001, 32'h0,
         32'h0, 32'h0, 32'hffffffff};
    send_item(d);
    d = {12{32'h80000000}};
    send_item(d);
    d = {12{32'h7fffffff}};
    send_item(d);
    d = {{3{32'hffffffff}}, {9{32'h7fffffff}}};
    send_item(d);
    for (int i = 0; i < 8; i++) send_item(rand_system());
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) stall_mode = $urandom_range(0, 2);
      send_item(rand_system());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 2'd0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    dim_model = DIM_RESET;
    err_cnt = 0;
    burst_left = 0;
    stall_mode = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(150);
    write_dim(DIM_2D);
    test_directed();
    test_random(150);
    write_dim(2'd0);
    test_random(80);
    write_dim(2'd1);
    test_random(80);
    write_dim(DIM_2D);
    test_random(60);
    write_dim(2'd3);
    test_random(60);
    drain();
    if (err_cnt == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
